// File: src/wpfm_pkg.sv
// ----------------------------------------------------------------------------
// wpfm_pkg - shared types and constants of the windowed pulse frequency meter
// Field widths, reset values, register map and derived sizing helpers.
// ----------------------------------------------------------------------------
package wpfm_pkg;

    localparam int COUNT_W          = 16;
    localparam int FREQ_W           = 16;
    localparam int INTERVAL_W       = 16;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int WINDOW_SLOTS_DEF = 20;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd200;
    localparam logic [FREQ_W-1:0]     FREQ_MAX       = 16'hFFFF;

    // word index of the sample interval register (byte address 0)
    localparam logic REG_SAMPLE_INTERVAL = 1'b0;

    typedef struct packed {
        logic [COUNT_W-1:0] count_b;
        logic [COUNT_W-1:0] count_a;
    } t_in_word;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_b;
        logic [FREQ_W-1:0] freq_a;
    } t_out_word;

    function automatic int slot_width(input int slots);
        return (slots > 1) ? $clog2(slots) : 1;
    endfunction

endpackage

// File: src/wpfm_prescaler.sv
// ----------------------------------------------------------------------------
// wpfm_prescaler - tick prescaler and shared window slot pointer
// Counts ticks up to the sample interval and steps the ring slot on a sample.
// ----------------------------------------------------------------------------
module wpfm_prescaler #(
    parameter  int WINDOW_SLOTS = wpfm_pkg::WINDOW_SLOTS_DEF,
    localparam int SLOT_W       = wpfm_pkg::slot_width(WINDOW_SLOTS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [wpfm_pkg::INTERVAL_W-1:0]   i_interval,
    output logic                              o_sample,
    output logic [SLOT_W-1:0]                 o_slot
);
    import wpfm_pkg::*;

    logic [INTERVAL_W-1:0] r_tick;
    logic [INTERVAL_W-1:0] n_tick;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W:0]       slot_inc;

    always_comb begin
        n_tick   = r_tick + 1'b1;
        o_sample = (n_tick >= i_interval);
        slot_inc = {1'b0, r_slot} + 1'b1;
        // wrap the ring pointer at the window length
        o_slot   = (slot_inc >= (SLOT_W+1)'(WINDOW_SLOTS)) ? '0 : slot_inc[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_slot <= '0;
        end else if (i_en) begin
            r_tick <= o_sample ? '0 : n_tick;
            if (o_sample) begin
                r_slot <= o_slot;
            end
        end
    end

endmodule

// File: src/wpfm_channel.sv
// ----------------------------------------------------------------------------
// wpfm_channel - one channel of the windowed frequency meter
// Holds the last counter sample, the window history and its running sum.
// ----------------------------------------------------------------------------
module wpfm_channel #(
    parameter  int WINDOW_SLOTS = wpfm_pkg::WINDOW_SLOTS_DEF,
    localparam int SLOT_W       = wpfm_pkg::slot_width(WINDOW_SLOTS)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_sample,
    input  logic [SLOT_W-1:0]               i_slot,
    input  logic [wpfm_pkg::COUNT_W-1:0]    i_count,
    output logic [wpfm_pkg::FREQ_W-1:0]     o_held
);
    import wpfm_pkg::*;

    localparam int SUM_W = COUNT_W + $clog2(WINDOW_SLOTS);

    logic [COUNT_W-1:0] r_last;
    logic [COUNT_W-1:0] r_hist [WINDOW_SLOTS];
    logic [SUM_W-1:0]   r_sum;
    logic [FREQ_W-1:0]  r_held;

    logic [COUNT_W-1:0] diff;
    logic [COUNT_W-1:0] old;
    logic [SUM_W-1:0]   n_sum;
    logic [FREQ_W-1:0]  sat;

    always_comb begin
        diff  = i_count - r_last;           // modulo 2^16, covers one wrap
        old   = r_hist[i_slot];
        // drop the leaving entry first so the sum never goes negative
        n_sum = (r_sum - SUM_W'(old)) + SUM_W'(diff);
        sat   = (n_sum > SUM_W'(FREQ_MAX)) ? FREQ_MAX : n_sum[FREQ_W-1:0];
        o_held = i_sample ? sat : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_sum  <= '0;
            r_held <= '0;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_en && i_sample) begin
            r_last         <= i_count;
            r_hist[i_slot] <= diff;
            r_sum          <= n_sum;
            r_held         <= sat;
        end
    end

endmodule

// File: src/windowed_pulse_frequency_meter_core.sv
// ----------------------------------------------------------------------------
// windowed_pulse_frequency_meter_core - two-channel moving window frequency meter
// Stream in counter snapshots, stream out windowed pulse counts.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one tick carrying the present values of two free-running
//   16-bit pulse counters. Every sample_interval ticks the block takes a sample:
//   the counter deltas since the previous sample enter a ring of WINDOW_SLOTS
//   slots and the window sums, saturated to 16 bits, become the held
//   frequencies. Every input word gives exactly one output word with both held
//   frequencies and a flag in tuser that is high on ticks that took a sample.
//   An input word passes through one input register, then the whole update
//   runs in one pass into the output register. Throughput is one word per
//   cycle while the receiver takes words; the update of prescaler, ring entry
//   and running sums in one pass sets this figure.
//   While the receiver stalls, the output register holds and the input
//   register still takes one more word; after that s_tready drops.
//   Reset clears the prescaler, the slot pointer, all history entries, sums
//   and held values, and sets sample_interval to 200. The interval register
//   sits at byte address 0 of the APB port; write it only while idle.
// ----------------------------------------------------------------------------
module windowed_pulse_frequency_meter_core #(
    parameter  int WINDOW_SLOTS = wpfm_pkg::WINDOW_SLOTS_DEF,
    localparam int SLOT_W       = wpfm_pkg::slot_width(WINDOW_SLOTS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [31:0]                       i_s_tdata,   // [15:0] count_a, [31:16] count_b
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [31:0]                       o_m_tdata,   // [15:0] freq_a, [31:16] freq_b
    output logic [0:0]                        o_m_tuser,   // [0] sampled
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wpfm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wpfm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wpfm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import wpfm_pkg::*;

    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_in_valid;
    t_in_word              r_in;
    logic                  r_out_valid;
    t_out_word             r_out;
    logic                  r_out_sampled;

    logic                  cfg_write;
    logic                  adv;
    logic                  smp;
    logic [SLOT_W-1:0]     slot;
    logic [FREQ_W-1:0]     held_a;
    logic [FREQ_W-1:0]     held_b;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SAMPLE_INTERVAL)
                     ? APB_DATA_W'(r_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (cfg_write && paddr[2] == REG_SAMPLE_INTERVAL) begin
            r_interval <= pwdata[INTERVAL_W-1:0];
        end
    end

    // advance the held word when the output register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= t_in_word'(i_s_tdata);
        end
    end

    wpfm_prescaler #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_prescaler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_interval (r_interval),
        .o_sample   (smp),
        .o_slot     (slot)
    );

    wpfm_channel #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_channel_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_sample (smp),
        .i_slot   (slot),
        .i_count  (r_in.count_a),
        .o_held   (held_a)
    );

    wpfm_channel #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_channel_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_sample (smp),
        .i_slot   (slot),
        .i_count  (r_in.count_b),
        .o_held   (held_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.freq_a  <= held_a;
            r_out.freq_b  <= held_b;
            r_out_sampled <= smp;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out;
    assign o_m_tuser[0] = r_out_sampled;

    // ring pointer stays inside the window
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, slot} < (SLOT_W+1)'(WINDOW_SLOTS))
        else $error("window slot pointer out of range");

    // with an interval above one, two consecutive ticks never both sample
    a_no_double_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && smp && r_interval > INTERVAL_W'(1) |=>
            !(adv && smp) || r_interval != $past(r_interval))
        else $error("back-to-back samples with interval above one");

    // a word blocked in the input register is neither lost nor altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("input register dropped or changed a blocked word");

endmodule

// File: sim/windowed_pulse_frequency_meter_core_test.sv
// ----------------------------------------------------------------------------
// windowed_pulse_frequency_meter_core_test - self-checking bench for the meter
// Streams counter snapshots into the core and checks every output word against
// an in-bench model of the prescaler, slot ring and windowed sums (typed table
// rows against their own values). A short table covers reset values, counter
// wrap, saturation and interval extremes; random phases with free-running
// counters follow, with bursty idling on both streams, one long output stall,
// and interval writes with read-back between phases.
// ----------------------------------------------------------------------------
module windowed_pulse_frequency_meter_core_test;

    import wpfm_pkg::*;

    localparam int          SLOTS        = WINDOW_SLOTS_DEF;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_WORDS  = 120;
    localparam logic [2:0]  ADDR_INTERVAL = 3'(REG_SAMPLE_INTERVAL) << 2;
    localparam logic [2:0]  ADDR_SPARE    = 3'd4;   // next word, no register behind it

    typedef struct packed {
        logic      took;
        t_out_word w;
    } t_meter_word;

    typedef struct packed {
        logic              cfg_wr;
        logic [2:0]        cfg_addr;
        logic [15:0]       cfg_val;
        logic [15:0]       cnt_a;
        logic [15:0]       cnt_b;
        logic              typed;
        logic [15:0]       exp_a;
        logic [15:0]       exp_b;
        logic              exp_s;
    } t_stim_row;

    localparam int N_ROWS = 17;
    localparam t_stim_row DIRECTED [N_ROWS] = '{
        // reset interval of 200: nothing sampled yet, held counts are zero
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 1'b0},
        // interval 1: first sample against zero history lands in slot one
        '{1'b1, ADDR_INTERVAL, 16'd1, 16'h0064, 16'hFFFF, 1'b1, 16'h0064, 16'hFFFF, 1'b1},
        // channel B sum passes 65535 and saturates
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h00C8, 16'hFFFE, 1'b1, 16'h00C8, 16'hFFFF, 1'b1},
        // both counters wrap
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0010, 16'h0001, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0010, 16'h0001, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // interval zero: every tick samples
        '{1'b1, ADDR_INTERVAL, 16'd0, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // write to the spare word is dropped
        '{1'b1, ADDR_SPARE,    16'd3, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0001, 16'h0002, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // largest interval: ticks only count up
        '{1'b1, ADDR_INTERVAL, 16'hFFFF, 16'h0100, 16'h0200, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0180, 16'h0300, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0200, 16'h0400, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0280, 16'h0500, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // interval dropped below the running count: next tick samples
        '{1'b1, ADDR_INTERVAL, 16'd2, 16'h0300, 16'h0600, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0380, 16'h0700, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{1'b0, ADDR_INTERVAL, 16'd0, 16'h0400, 16'h0800, 1'b0, 16'h0000, 16'h0000, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;     // [15:0] count_a, [31:16] count_b
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;     // [15:0] freq_a, [31:16] freq_b
    logic [0:0]  o_m_tuser;     // [0] sampled
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    windowed_pulse_frequency_meter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // meter model state
    logic [15:0]  cfg_interval;
    logic [15:0]  tick_cnt;
    int unsigned  slot_idx;
    logic [15:0]  prev_a, prev_b;
    logic [15:0]  ring_a [SLOTS];
    logic [15:0]  ring_b [SLOTS];
    logic [20:0]  wsum_a, wsum_b;
    logic [15:0]  held_a, held_b;

    t_meter_word  pending_freqs [$];
    int           mismatches    = 0;
    int           words_checked = 0;
    int           samples_seen  = 0;
    int           cycle_cnt     = 0;
    int           rx_gap        = 0;
    int           hold_cnt      = 0;
    bit           long_hold_req = 1'b0;
    bit           idle_on       = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_meter_word meter_tick(input logic [15:0] a, input logic [15:0] b);
        t_meter_word r;
        logic [15:0] da;
        logic [15:0] db;
        r.took   = 1'b0;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= cfg_interval) begin
            tick_cnt = '0;
            r.took   = 1'b1;
            slot_idx = (slot_idx + 1 >= SLOTS) ? 0 : slot_idx + 1;
            da       = a - prev_a;
            db       = b - prev_b;
            prev_a   = a;
            prev_b   = b;
            wsum_a   = wsum_a + 21'(da) - 21'(ring_a[slot_idx]);
            wsum_b   = wsum_b + 21'(db) - 21'(ring_b[slot_idx]);
            ring_a[slot_idx] = da;
            ring_b[slot_idx] = db;
            held_a   = (wsum_a > 21'(FREQ_MAX)) ? FREQ_MAX : wsum_a[15:0];
            held_b   = (wsum_b > 21'(FREQ_MAX)) ? FREQ_MAX : wsum_b[15:0];
        end
        r.w.freq_a = held_a;
        r.w.freq_b = held_b;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (mismatches < 10)
            $display("mismatch: %s expected 0x%0h got 0x%0h (word %0d)",
                     what, exp_v, act_v, words_checked);
        mismatches++;
    endtask

    // free-running counter: mostly small steps, some large jumps and wraps
    task automatic next_count(inout logic [15:0] c);
        case ($urandom_range(0, 9))
            0:       c = 16'($urandom);
            1:       c = c + 16'($urandom_range(1000, 65535));
            default: c = c + 16'($urandom_range(0, 40));
        endcase
    endtask

    task automatic send_word(input logic [15:0] a, input logic [15:0] b,
                             input bit typed, input t_meter_word typed_exp);
        t_meter_word pred;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        do @(posedge i_clk); while (!o_s_tready);
        pred = meter_tick(a, b);
        pending_freqs.push_back(typed ? typed_exp : pred);
    endtask

    // drop valid, wait for every word to come back, then let the pipe empty
    task automatic settle_meter();
        i_s_tvalid <= 1'b0;
        while (pending_freqs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wd,
                            output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wd;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        rd = prdata;
        @(posedge i_clk);
    endtask

    task automatic write_interval_reg(input logic [2:0] addr, input logic [15:0] val);
        logic [31:0] rd;
        settle_meter();
        apb_xfer(1'b1, addr, {16'h0, val}, rd);
        if (addr == ADDR_INTERVAL)
            cfg_interval = val;
        apb_xfer(1'b0, ADDR_INTERVAL, '0, rd);
        if (rd !== {16'h0, cfg_interval})
            note_mismatch("interval read-back", {16'h0, cfg_interval}, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random short stalls, plus one long hold counted here
    always @(posedge i_clk) begin
        if (long_hold_req && hold_cnt < LONG_HOLD) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= hold_cnt + 1;
        end else if (rx_gap != 0) begin
            i_m_tready <= 1'b0;
            rx_gap     <= rx_gap - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            rx_gap     <= $urandom_range(0, 4);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_meter_word exp_w;
        t_out_word   got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_freqs.size() == 0) begin
                note_mismatch("word with nothing pending", 32'h0, o_m_tdata);
            end else begin
                exp_w = pending_freqs.pop_front();
                if (got.freq_a !== exp_w.w.freq_a)
                    note_mismatch("freq_a", 32'(exp_w.w.freq_a), 32'(got.freq_a));
                if (got.freq_b !== exp_w.w.freq_b)
                    note_mismatch("freq_b", 32'(exp_w.w.freq_b), 32'(got.freq_b));
                if (o_m_tuser[0] !== exp_w.took)
                    note_mismatch("sampled", 32'(exp_w.took), 32'(o_m_tuser[0]));
                if (exp_w.took)
                    samples_seen++;
            end
            words_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_cnt, pending_freqs.size());
            $display("windowed_pulse_frequency_meter_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        int          p;
        int          n;
        int          words;
        logic [15:0] ctr_a;
        logic [15:0] ctr_b;
        logic [15:0] iv;
        t_meter_word row_exp;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        cfg_interval = INTERVAL_RESET;
        tick_cnt     = '0;
        slot_idx     = 0;
        prev_a       = '0;
        prev_b       = '0;
        wsum_a       = '0;
        wsum_b       = '0;
        held_a       = '0;
        held_b       = '0;
        for (n = 0; n < SLOTS; n++) begin
            ring_a[n] = '0;
            ring_b[n] = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;

        for (n = 0; n < N_ROWS; n++) begin
            if (DIRECTED[n].cfg_wr)
                write_interval_reg(DIRECTED[n].cfg_addr, DIRECTED[n].cfg_val);
            row_exp.took     = DIRECTED[n].exp_s;
            row_exp.w.freq_a = DIRECTED[n].exp_a;
            row_exp.w.freq_b = DIRECTED[n].exp_b;
            send_word(DIRECTED[n].cnt_a, DIRECTED[n].cnt_b, DIRECTED[n].typed, row_exp);
        end
        ctr_a = DIRECTED[N_ROWS-1].cnt_a;
        ctr_b = DIRECTED[N_ROWS-1].cnt_b;

        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       iv = 16'd1;
                1:       iv = 16'd0;
                2:       iv = 16'd3;
                3:       iv = 16'hFFFF;
                4:       iv = 16'd6;      // below the count left by the long phase
                5:       iv = 16'd2;
                default: iv = 16'($urandom_range(1, 12));
            endcase
            write_interval_reg(ADDR_INTERVAL, iv);
            if (p == 1)
                long_hold_req <= 1'b1;
            if (p == RAND_PHASES - 1)
                idle_on <= 1'b0;
            words = (iv == 16'hFFFF) ? 40 : PHASE_WORDS;
            for (n = 0; n < words; n++) begin
                next_count(ctr_a);
                next_count(ctr_b);
                send_word(ctr_a, ctr_b, 1'b0, row_exp);
            end
        end

        settle_meter();
        $display("checked %0d output words, %0d of them sample ticks, over %0d phases",
                 words_checked, samples_seen, RAND_PHASES + 5);
        $display("intervals 0, 1 to 65535, a dropped spare-register write and a %0d-cycle stall",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("windowed_pulse_frequency_meter_core_test: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("windowed_pulse_frequency_meter_core_test: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
src/wpfm_pkg.sv
src/wpfm_prescaler.sv
src/wpfm_channel.sv
src/windowed_pulse_frequency_meter_core.sv
sim/windowed_pulse_frequency_meter_core_test.sv
